### src/vector_refraction_top_assert.svh
// Assertion macros used by the checker file.
`ifndef VECTOR_REFRACTION_TOP_ASSERT_SVH
`define VECTOR_REFRACTION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vr_pkg.sv
package vr_pkg;

  localparam int COMP_W    = 16;  // component width, Q3.12 by default
  localparam int FRAC_BITS = 12;
  localparam int ETA_W     = 16;  // eta is unsigned Q2.14
  localparam int ETA_FRAC  = 14;

  localparam logic signed [63:0] INNER_LIMIT = 64'sd2147483647;

  typedef struct packed {
    logic signed [COMP_W-1:0] incident_x;
    logic signed [COMP_W-1:0] incident_y;
    logic signed [COMP_W-1:0] incident_z;
    logic signed [COMP_W-1:0] incident_w;
    logic signed [COMP_W-1:0] normal_x;
    logic signed [COMP_W-1:0] normal_y;
    logic signed [COMP_W-1:0] normal_z;
    logic signed [COMP_W-1:0] normal_w;
    logic        [ETA_W-1:0]  index_ratio;
  } in_item_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] refracted_x;
    logic signed [COMP_W-1:0] refracted_y;
    logic signed [COMP_W-1:0] refracted_z;
    logic signed [COMP_W-1:0] refracted_w;
    logic                     total_reflection;
  } out_item_t;

endpackage

### src/vector_refraction_top.sv
// Snell refraction of a 4-component direction against a surface normal.
//
// Input channel in_valid/in_ready/in_data carries the incident vector, the
// normal (both signed, FRACTION_BITS fraction bits) and eta (unsigned Q2.14).
// Output channel out_valid/out_ready/out_data returns the refracted vector,
// saturated, plus total_reflection; the vector is all zero when it is set.
// One result item per input item, in order.
//
// The square root pipeline has RW stages, where RW is the number of root
// bits (one bit per stage); at FRACTION_BITS = 12, RW is 25. Throughput is
// one item per cycle while out_ready does not stall the pipe; the pipeline
// stages ahead of and behind the root chain are fixed.
//
// Every stage holds its own valid bit and advances when it is empty or the
// stage after it moves, so a stall at out_ready fills empty slots first and
// in_ready stays high while any bubble remains. Synchronous active-low reset
// clears all valid bits; nothing is in flight afterwards.
module vector_refraction_top #(
  parameter int FRACTION_BITS = vr_pkg::FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vr_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vr_pkg::out_item_t out_data
);
  import vr_pkg::*;

  localparam int FB = FRACTION_BITS;

  // Widths of the intermediate values. The cosine can never reach the
  // 31-bit inner limit with 16-bit components, so it needs no clamp.
  localparam int P1W    = (2 * COMP_W - FB > 1) ? 2 * COMP_W - FB : 1;
  localparam int COS_W  = 2 * COMP_W - FB + 1;
  localparam int EI_W   = COMP_W + ETA_W + 1 - ETA_FRAC;
  localparam int EC_W   = COS_W + ETA_W + 1 - ETA_FRAC;
  localparam int SQ_W   = (2 * COS_W - FB > 1) ? 2 * COS_W - FB : 1;
  localparam int SIN_RW = (SQ_W + 2 > FB + 2) ? SQ_W + 2 : FB + 2;
  localparam int SIN_W  = (SIN_RW < 32) ? SIN_RW : 32;
  localparam int TP_W   = 2 * ETA_W + 1 + SIN_W;
  localparam int TERM_W = TP_W - 2 * ETA_FRAC;
  localparam int C2_W   = TERM_W + 1;
  localparam int C2P_W  = (C2_W - 1 < 62 - FB) ? C2_W - 1 : 62 - FB;
  localparam int RAD_W  = C2P_W + FB;
  localparam int RW     = (RAD_W + 1) / 2;
  localparam int RAD_PW = 2 * RW;
  localparam int KR_W   = ((EC_W > RW + 1) ? EC_W : RW + 1) + 1;
  localparam int K_W    = (KR_W < 32) ? KR_W : 32;
  localparam int KN_W   = (K_W + COMP_W - FB > 1) ? K_W + COMP_W - FB : 1;
  localparam int V_W    = ((EI_W > KN_W) ? EI_W : KN_W) + 1;

  // Stage positions: six front stages, RW root stages, coefficient,
  // products, output register.
  localparam int SQ0 = 6;
  localparam int KS  = SQ0 + RW;
  localparam int MS  = KS + 1;
  localparam int OS  = MS + 1;
  localparam int NST = OS + 1;

  localparam logic signed [63:0] ONE     = 64'sd1 <<< FB;
  localparam logic signed [63:0] LIM     = INNER_LIMIT;
  localparam logic signed [63:0] NEG_LIM = -INNER_LIMIT;
  localparam logic signed [63:0] RAD_LIM = (64'sd1 <<< (62 - FB)) - 64'sd1;
  localparam logic signed [63:0] OMAX    = (64'sd1 <<< (COMP_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OMIN    = -(64'sd1 <<< (COMP_W - 1));

  typedef struct packed {
    logic [2:0][P1W-1:0]    p;
    logic [3:0][COMP_W-1:0] nrm;
    logic [3:0][EI_W-1:0]   ei;
    logic [ETA_W-1:0]       eta;
    logic [2*ETA_W-1:0]     eta2;
    logic [COS_W-1:0]       cosv;
    logic [EC_W-1:0]        ec;
    logic [SQ_W-1:0]        sq;
    logic [SIN_W-1:0]       sin2;
    logic [TERM_W-1:0]      term;
    logic                   flag;
    logic [RAD_PW-1:0]      rad;
    logic [RW:0]            rem;
    logic [RW-1:0]          root;
    logic [K_W-1:0]         k;
    logic [3:0][KN_W-1:0]   kn;
  } pipe_t;

  function automatic logic signed [63:0] clamp_s64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
    logic signed [63:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_in;
  logic [NST-1:0] rdy;

  pipe_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, k_r, m_r;
  pipe_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, k_nxt, m_nxt;
  pipe_t sqrt_r [RW];
  out_item_t out_r, out_nxt;

  // ---------------- handshake ----------------
  assign v_in = {v_r[NST-2:0], in_valid};
  assign rdy[OS] = !v_r[OS] || out_ready;

  for (genvar i = 0; i < OS; i++) begin : g_rdy
    assign rdy[i] = !v_r[i] || rdy[i+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[OS];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  // ---------------- stage 1: products ----------------
  always_comb begin
    logic signed [COMP_W-1:0]       inc_v [4];
    logic signed [COMP_W-1:0]       nrm_v [4];
    logic signed [2*COMP_W-1:0]     dprod;
    logic signed [ETA_W+COMP_W:0]   eip;
    s1_nxt   = '0;
    inc_v[0] = in_data.incident_x;
    inc_v[1] = in_data.incident_y;
    inc_v[2] = in_data.incident_z;
    inc_v[3] = in_data.incident_w;
    nrm_v[0] = in_data.normal_x;
    nrm_v[1] = in_data.normal_y;
    nrm_v[2] = in_data.normal_z;
    nrm_v[3] = in_data.normal_w;
    for (int j = 0; j < 3; j++) begin
      dprod = inc_v[j] * nrm_v[j];
      s1_nxt.p[j] = P1W'(dprod >>> FB);
    end
    for (int j = 0; j < 4; j++) begin
      eip = $signed({1'b0, in_data.index_ratio}) * inc_v[j];
      s1_nxt.ei[j]  = EI_W'(eip >>> ETA_FRAC);
      s1_nxt.nrm[j] = nrm_v[j];
    end
    s1_nxt.eta  = in_data.index_ratio;
    s1_nxt.eta2 = in_data.index_ratio * in_data.index_ratio;
  end

  // ---------------- stage 2: cosine ----------------
  always_comb begin
    logic signed [COS_W-1:0] dsum;
    s2_nxt = s1_r;
    dsum = COS_W'($signed(s1_r.p[0])) + COS_W'($signed(s1_r.p[1]))
         + COS_W'($signed(s1_r.p[2]));
    s2_nxt.cosv = -dsum;
  end

  // ---------------- stage 3: cos^2, eta*cos ----------------
  always_comb begin
    logic signed [COS_W-1:0]         cosv_s;
    logic signed [2*COS_W-1:0]       sqf;
    logic signed [ETA_W+COS_W:0]     ecp;
    s3_nxt = s2_r;
    cosv_s = $signed(s2_r.cosv);
    sqf    = cosv_s * cosv_s;
    ecp    = $signed({1'b0, s2_r.eta}) * cosv_s;
    s3_nxt.sq = SQ_W'(sqf >>> FB);
    s3_nxt.ec = EC_W'(ecp >>> ETA_FRAC);
  end

  // ---------------- stage 4: sin^2 ----------------
  always_comb begin
    logic signed [SIN_RW-1:0] sraw;
    s4_nxt = s3_r;
    sraw = $signed(SIN_RW'(ONE)) - $signed(SIN_RW'(s3_r.sq));
    s4_nxt.sin2 = SIN_W'(clamp_s64(64'(sraw), NEG_LIM, LIM));
  end

  // ---------------- stage 5: eta^2 * sin^2 ----------------
  always_comb begin
    logic signed [TP_W-1:0] tprod;
    s5_nxt = s4_r;
    tprod  = $signed({1'b0, s4_r.eta2}) * $signed(s4_r.sin2);
    s5_nxt.term = TERM_W'(tprod >>> (2 * ETA_FRAC));
  end

  // ---------------- stage 6: cost2, reflection test, radicand ----------------
  always_comb begin
    logic signed [C2_W-1:0] c2;
    logic signed [63:0]     c2c;
    s6_nxt = s5_r;
    c2  = $signed(C2_W'(ONE)) - C2_W'($signed(s5_r.term));
    c2c = clamp_s64(64'(c2), 64'sd0, RAD_LIM);
    s6_nxt.flag = (c2 <= 0);
    s6_nxt.rad  = RAD_PW'(c2c <<< FB);
    s6_nxt.rem  = '0;
    s6_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s1_r <= s1_nxt;
    if (rdy[1]) s2_r <= s2_nxt;
    if (rdy[2]) s3_r <= s3_nxt;
    if (rdy[3]) s4_r <= s4_nxt;
    if (rdy[4]) s5_r <= s5_nxt;
    if (rdy[5]) s6_r <= s6_nxt;
  end

  // ---------------- square root: one root bit per stage ----------------
  for (genvar t = 0; t < RW; t++) begin : g_root
    pipe_t src;
    pipe_t sqrt_nxt;

    if (t == 0) begin : g_first
      assign src = s6_r;
    end else begin : g_next
      assign src = sqrt_r[t-1];
    end

    always_comb begin
      logic [RW+2:0] r2;
      logic [RW+2:0] trial;
      logic          ge;
      sqrt_nxt = src;
      r2    = {src.rem, src.rad[RAD_PW-1-2*t -: 2]};
      trial = (RW + 3)'({src.root, 2'b01});
      ge    = (r2 >= trial);
      sqrt_nxt.rem  = ge ? (RW + 1)'(r2 - trial) : (RW + 1)'(r2);
      sqrt_nxt.root = {src.root[RW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rdy[SQ0+t]) begin
        sqrt_r[t] <= sqrt_nxt;
      end
    end
  end

  // ---------------- coefficient k = eta*cos - root ----------------
  always_comb begin
    logic signed [KR_W-1:0] kraw;
    k_nxt = sqrt_r[RW-1];
    kraw  = $signed(KR_W'($signed(sqrt_r[RW-1].ec))) - $signed(KR_W'(sqrt_r[RW-1].root));
    k_nxt.k = K_W'(clamp_s64(64'(kraw), NEG_LIM, LIM));
  end

  // ---------------- k * normal ----------------
  always_comb begin
    logic signed [K_W+COMP_W-1:0] knp;
    m_nxt = k_r;
    for (int j = 0; j < 4; j++) begin
      knp = $signed(k_r.k) * $signed(k_r.nrm[j]);
      m_nxt.kn[j] = KN_W'(knp >>> FB);
    end
  end

  // ---------------- sum and saturate ----------------
  always_comb begin
    logic signed [V_W-1:0]    vs;
    logic signed [COMP_W-1:0] res [4];
    for (int j = 0; j < 4; j++) begin
      vs = V_W'($signed(m_r.ei[j])) + V_W'($signed(m_r.kn[j]));
      res[j] = m_r.flag ? '0 : COMP_W'(clamp_s64(64'(vs), OMIN, OMAX));
    end
    out_nxt.refracted_x      = res[0];
    out_nxt.refracted_y      = res[1];
    out_nxt.refracted_z      = res[2];
    out_nxt.refracted_w      = res[3];
    out_nxt.total_reflection = m_r.flag;
  end

  always_ff @(posedge clk) begin
    if (rdy[KS]) k_r   <= k_nxt;
    if (rdy[MS]) m_r   <= m_nxt;
    if (rdy[OS]) out_r <= out_nxt;
  end

endmodule

### src/vr_checker.sv
`include "vector_refraction_top_assert.svh"

module vr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input vr_pkg::out_item_t out_data
);
  import vr_pkg::*;

  // a stalled result item holds still
  `VR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out item changed while stalled")

  // total reflection always comes with the zero vector
  `VR_ASSERT_NOW(a_tir_zero, out_valid && out_data.total_reflection, out_data.refracted_x == '0 && out_data.refracted_y == '0 && out_data.refracted_z == '0 && out_data.refracted_w == '0, "total reflection with nonzero vector")

  // whenever the output slot frees up, the pipe can take an item
  `VR_ASSERT_NOW(a_in_ready, !out_valid || out_ready, in_ready, "in_ready low while output can drain")

endmodule

bind vector_refraction_top vr_checker u_vr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
